// ===== hdl/bacm_pkg.sv =====
// Shared types, widths and box helpers for the cluster merge block.
// No dependencies.
package bacm_pkg;

  localparam int MAX_CLUSTERS = 32;
  localparam int COORD_BITS   = 16;
  localparam int ID_BITS      = 16;

  localparam int SLOT_BITS = $clog2(MAX_CLUSTERS);
  localparam int CNT_BITS  = $clog2(MAX_CLUSTERS + 1);
  localparam int EXT_BITS  = COORD_BITS + 1;
  localparam int PROD_BITS = 2 * EXT_BITS;
  localparam int AREA_BITS = PROD_BITS + 2;

  localparam int TGT_BITS     = 6;
  localparam int AXIS_BITS    = 2;
  localparam int FIRST_BITS   = 16;
  localparam int CFG_IDX_BITS = 2;
  localparam int CFG_DATA_BITS = 16;

  localparam logic [CFG_IDX_BITS-1:0] REG_TARGET   = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_AXIS     = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_FIRST_ID = 2'd2;

  localparam logic KIND_NODE     = 1'b0;
  localparam logic KIND_SURVIVOR = 1'b1;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [EXT_BITS-1:0]   ext_t;
  typedef logic signed [AREA_BITS-1:0]  area_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } box_t;

  typedef struct packed {
    logic [ID_BITS-1:0] id;
    box_t               box;
  } entry_t;

  function automatic coord_t cmin(coord_t a, coord_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic coord_t cmax(coord_t a, coord_t b);
    return (a > b) ? a : b;
  endfunction

  function automatic box_t merge_box(box_t a, box_t b);
    box_t m;
    m.min_x = cmin(a.min_x, b.min_x);
    m.min_y = cmin(a.min_y, b.min_y);
    m.min_z = cmin(a.min_z, b.min_z);
    m.max_x = cmax(a.max_x, b.max_x);
    m.max_y = cmax(a.max_y, b.max_y);
    m.max_z = cmax(a.max_z, b.max_z);
    return m;
  endfunction

endpackage

// ===== hdl/bvh_agglomerative_cluster_merge.sv =====
// Agglomerative cluster merge: loads cluster boxes, merges best pairs, emits nodes.
// Depends on bacm_pkg, bacm_ram, bacm_area.
// A non-final cluster is taken on start while idle. The final one starts the pass,
// which is bound by the shared area unit: n*(n-1) areas to seed, then per merge
// n areas, one scan for the new node and one per stale link. Results are strobed
// for one cycle each; the receiver cannot stall. Reset restores defaults.
module bvh_agglomerative_cluster_merge (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  bacm_pkg::coord_t                  box_min_x,
  input  bacm_pkg::coord_t                  box_min_y,
  input  bacm_pkg::coord_t                  box_min_z,
  input  bacm_pkg::coord_t                  box_max_x,
  input  bacm_pkg::coord_t                  box_max_y,
  input  bacm_pkg::coord_t                  box_max_z,
  input  logic [bacm_pkg::ID_BITS-1:0]      cluster_id,
  input  logic                              last_cluster,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bacm_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  logic [bacm_pkg::CFG_DATA_BITS-1:0] cfg_data,
  output logic                              result_strobe,
  output logic                              kind,
  output logic [bacm_pkg::ID_BITS-1:0]      node_id,
  output logic [bacm_pkg::ID_BITS-1:0]      left_child,
  output logic [bacm_pkg::ID_BITS-1:0]      right_child,
  output logic [bacm_pkg::AXIS_BITS-1:0]    node_axis,
  output bacm_pkg::coord_t                  out_min_x,
  output bacm_pkg::coord_t                  out_min_y,
  output bacm_pkg::coord_t                  out_min_z,
  output bacm_pkg::coord_t                  out_max_x,
  output bacm_pkg::coord_t                  out_max_y,
  output bacm_pkg::coord_t                  out_max_z,
  output logic                              run_end
);
  import bacm_pkg::*;

  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_INIT     = 5'd1;
  localparam logic [4:0] S_INIT_NX  = 5'd2;
  localparam logic [4:0] S_SRCH     = 5'd3;
  localparam logic [4:0] S_SRCH_RET = 5'd4;
  localparam logic [4:0] S_RD1      = 5'd5;
  localparam logic [4:0] S_ASTART   = 5'd6;
  localparam logic [4:0] S_AW       = 5'd7;
  localparam logic [4:0] S_MCHK     = 5'd8;
  localparam logic [4:0] S_BP       = 5'd9;
  localparam logic [4:0] S_BP_RET   = 5'd10;
  localparam logic [4:0] S_MRG1     = 5'd11;
  localparam logic [4:0] S_MRG3     = 5'd12;
  localparam logic [4:0] S_CP2      = 5'd13;
  localparam logic [4:0] S_WDST     = 5'd14;
  localparam logic [4:0] S_FIX0     = 5'd15;
  localparam logic [4:0] S_FIX      = 5'd16;
  localparam logic [4:0] S_FIX_NX   = 5'd17;
  localparam logic [4:0] S_EMIT     = 5'd18;
  localparam logic [4:0] S_EMIT2    = 5'd19;

  logic [4:0] state, sret, rd_ret, aret;

  logic [TGT_BITS-1:0]   target_clusters;
  logic [AXIS_BITS-1:0]  split_axis;
  logic [ID_BITS-1:0]    next_id;
  logic [CNT_BITS-1:0]   live_count, limit;
  logic [CNT_BITS-1:0]   i, j;
  logic [SLOT_BITS-1:0]  tgt, best, left, right, last, dst;
  logic [SLOT_BITS-1:0]  ra, rb;
  logic [SLOT_BITS-1:0]  nearest [MAX_CLUSTERS];
  logic [SLOT_BITS-1:0]  near_i;
  logic                  found;
  area_t                 bd;
  box_t                  mbox, mrg;

  logic                  ram_we;
  logic [SLOT_BITS-1:0]  ram_waddr;
  entry_t                ram_wdata, rd_a, rd_b, in_entry;

  logic                  area_start, area_done;
  area_t                 area;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign limit     = (target_clusters == '0) ? CNT_BITS'(1) : CNT_BITS'(target_clusters);
  assign near_i    = nearest[i[SLOT_BITS-1:0]];
  assign mrg       = merge_box(rd_a.box, rd_b.box);
  assign area_start = (state == S_ASTART);

  assign in_entry.id        = cluster_id;
  assign in_entry.box.min_x = box_min_x;
  assign in_entry.box.min_y = box_min_y;
  assign in_entry.box.min_z = box_min_z;
  assign in_entry.box.max_x = box_max_x;
  assign in_entry.box.max_y = box_max_y;
  assign in_entry.box.max_z = box_max_z;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = live_count[SLOT_BITS-1:0];
    ram_wdata = in_entry;
    case (state)
      S_IDLE: begin
        ram_we = start && (live_count < CNT_BITS'(MAX_CLUSTERS));
      end
      S_CP2: begin
        ram_we    = 1'b1;
        ram_waddr = right;
        ram_wdata = rd_a;
      end
      S_WDST: begin
        ram_we        = 1'b1;
        ram_waddr     = dst;
        ram_wdata.id  = next_id;
        ram_wdata.box = mbox;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  bacm_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_CLUSTERS)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ra),
    .rdata_a (rd_a),
    .raddr_b (rb),
    .rdata_b (rd_b)
  );

  bacm_area u_area (
    .clk   (clk),
    .rst   (rst),
    .start (area_start),
    .box_a (rd_a.box),
    .box_b (rd_b.box),
    .done  (area_done),
    .area  (area)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      live_count      <= '0;
      next_id         <= '0;
      target_clusters <= TGT_BITS'(1);
      split_axis      <= AXIS_BITS'(2);
      result_strobe   <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TARGET:   target_clusters <= cfg_data[TGT_BITS-1:0];
          REG_AXIS:     split_axis      <= cfg_data[AXIS_BITS-1:0];
          REG_FIRST_ID: next_id         <= ID_BITS'(cfg_data[FIRST_BITS-1:0]);
          default: ;
        endcase
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            if (live_count < CNT_BITS'(MAX_CLUSTERS)) begin
              live_count <= live_count + CNT_BITS'(1);
            end
            if (last_cluster) begin
              i     <= '0;
              state <= S_INIT;
            end
          end
        end
        S_INIT: begin
          if (i == live_count) begin
            state <= S_MCHK;
          end else begin
            tgt   <= i[SLOT_BITS-1:0];
            best  <= i[SLOT_BITS-1:0];
            j     <= '0;
            found <= 1'b0;
            sret  <= S_INIT_NX;
            state <= S_SRCH;
          end
        end
        S_INIT_NX: begin
          i     <= i + CNT_BITS'(1);
          state <= S_INIT;
        end
        S_SRCH: begin
          if (j == live_count) begin
            nearest[tgt] <= best;
            state        <= sret;
          end else if (j[SLOT_BITS-1:0] == tgt) begin
            j <= j + CNT_BITS'(1);
          end else begin
            ra     <= tgt;
            rb     <= j[SLOT_BITS-1:0];
            rd_ret <= S_ASTART;
            aret   <= S_SRCH_RET;
            state  <= S_RD1;
          end
        end
        S_SRCH_RET: begin
          if (!found || area < bd) begin
            found <= 1'b1;
            bd    <= area;
            best  <= j[SLOT_BITS-1:0];
          end
          j     <= j + CNT_BITS'(1);
          state <= S_SRCH;
        end
        S_RD1: begin
          state <= rd_ret;
        end
        S_ASTART: begin
          state <= S_AW;
        end
        S_AW: begin
          if (area_done) begin
            state <= aret;
          end
        end
        S_MCHK: begin
          i     <= '0;
          found <= 1'b0;
          state <= (live_count > limit) ? S_BP : S_EMIT;
        end
        S_BP: begin
          if (i == live_count) begin
            state <= S_MRG1;
          end else begin
            ra     <= i[SLOT_BITS-1:0];
            rb     <= near_i;
            rd_ret <= S_ASTART;
            aret   <= S_BP_RET;
            state  <= S_RD1;
          end
        end
        S_BP_RET: begin
          if (!found || area < bd) begin
            found <= 1'b1;
            bd    <= area;
            left  <= i[SLOT_BITS-1:0];
          end
          i     <= i + CNT_BITS'(1);
          state <= S_BP;
        end
        S_MRG1: begin
          right  <= nearest[left];
          ra     <= left;
          rb     <= nearest[left];
          last   <= SLOT_BITS'(live_count - CNT_BITS'(1));
          rd_ret <= S_MRG3;
          state  <= S_RD1;
        end
        S_MRG3: begin
          mbox          <= mrg;
          result_strobe <= 1'b1;
          kind          <= KIND_NODE;
          node_id       <= next_id;
          left_child    <= rd_a.id;
          right_child   <= rd_b.id;
          node_axis     <= split_axis;
          out_min_x     <= mrg.min_x;
          out_min_y     <= mrg.min_y;
          out_min_z     <= mrg.min_z;
          out_max_x     <= mrg.max_x;
          out_max_y     <= mrg.max_y;
          out_max_z     <= mrg.max_z;
          run_end       <= 1'b0;
          if (left == last) begin
            dst   <= right;
            state <= S_WDST;
          end else begin
            dst <= left;
            if (right != last) begin
              ra     <= last;
              rd_ret <= S_CP2;
              state  <= S_RD1;
            end else begin
              state <= S_WDST;
            end
          end
        end
        S_CP2: begin
          nearest[right] <= nearest[last];
          state          <= S_WDST;
        end
        S_WDST: begin
          next_id    <= next_id + ID_BITS'(1);
          live_count <= live_count - CNT_BITS'(1);
          tgt        <= dst;
          best       <= dst;
          j          <= '0;
          found      <= 1'b0;
          sret       <= S_FIX0;
          state      <= S_SRCH;
        end
        S_FIX0: begin
          i     <= '0;
          state <= S_FIX;
        end
        S_FIX: begin
          if (i == live_count) begin
            state <= S_MCHK;
          end else if (i[SLOT_BITS-1:0] == dst) begin
            i <= i + CNT_BITS'(1);
          end else if (near_i == left || near_i == right) begin
            tgt   <= i[SLOT_BITS-1:0];
            best  <= i[SLOT_BITS-1:0];
            j     <= '0;
            found <= 1'b0;
            sret  <= S_FIX_NX;
            state <= S_SRCH;
          end else begin
            if (near_i == last) begin
              nearest[i[SLOT_BITS-1:0]] <= right;
            end
            i <= i + CNT_BITS'(1);
          end
        end
        S_FIX_NX: begin
          i     <= i + CNT_BITS'(1);
          state <= S_FIX;
        end
        S_EMIT: begin
          if (i == live_count) begin
            live_count <= '0;
            state      <= S_IDLE;
          end else begin
            ra     <= i[SLOT_BITS-1:0];
            rd_ret <= S_EMIT2;
            state  <= S_RD1;
          end
        end
        S_EMIT2: begin
          result_strobe <= 1'b1;
          kind          <= KIND_SURVIVOR;
          node_id       <= rd_a.id;
          left_child    <= '0;
          right_child   <= '0;
          node_axis     <= '0;
          out_min_x     <= rd_a.box.min_x;
          out_min_y     <= rd_a.box.min_y;
          out_min_z     <= rd_a.box.min_z;
          out_max_x     <= rd_a.box.max_x;
          out_max_y     <= rd_a.box.max_y;
          out_max_z     <= rd_a.box.max_z;
          run_end       <= (i == live_count - CNT_BITS'(1));
          i             <= i + CNT_BITS'(1);
          state         <= S_EMIT;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/bacm_ram.sv =====
// Generic RAM, one write port and two registered read ports.
// No dependencies.
module bacm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

// ===== hdl/bacm_area.sv =====
// Half surface area of the merged box of two clusters, one shared multiplier.
// Depends on bacm_pkg.
module bacm_area (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  bacm_pkg::box_t  box_a,
  input  bacm_pkg::box_t  box_b,
  output logic            done,
  output bacm_pkg::area_t area
);
  import bacm_pkg::*;

  box_t                  m;
  ext_t                  ex, ey, ez;
  ext_t                  op_a, op_b;
  logic signed [PROD_BITS-1:0] prod;
  logic [1:0]            phase;
  logic                  run;

  assign m = merge_box(box_a, box_b);

  always_comb begin
    case (phase)
      2'd0: begin
        op_a = ex;
        op_b = ey;
      end
      2'd1: begin
        op_a = ey;
        op_b = ez;
      end
      default: begin
        op_a = ez;
        op_b = ex;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run   <= 1'b0;
      done  <= 1'b0;
      phase <= 2'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run   <= 1'b1;
        phase <= 2'd0;
        ex    <= ext_t'(m.max_x) - ext_t'(m.min_x);
        ey    <= ext_t'(m.max_y) - ext_t'(m.min_y);
        ez    <= ext_t'(m.max_z) - ext_t'(m.min_z);
        prod  <= '0;
        area  <= '0;
      end else if (run) begin
        prod <= op_a * op_b;
        area <= area + area_t'(prod);
        if (phase == 2'd3) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
        phase <= phase + 2'd1;
      end
    end
  end

endmodule
